>>> hdl/okvt_pkg.sv
// ----------------------------------------------------------------------------
// okvt_pkg
// Shared types and constants of the ordered key-value table.
// ----------------------------------------------------------------------------
package okvt_pkg;

  // Default sizes of the table.
  localparam int unsigned DEPTH_DEF      = 64;
  localparam int unsigned KEY_BITS_DEF   = 32;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // Fixed widths of the item fields on the ports.
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned COUNT_W = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT     = 2'd0,
    CMD_ERASE   = 2'd1,
    CMD_GET_KEY = 2'd2,
    CMD_GET_POS = 2'd3
  } cmd_e;

  // Access strobes of the entry memory.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

>>> hdl/okvt_if.sv
// ----------------------------------------------------------------------------
// okvt_if
// Command and result channels of the ordered key-value table.
// ----------------------------------------------------------------------------
interface okvt_req_if;
  logic                        valid;
  logic                        ready;
  logic [okvt_pkg::CMD_W-1:0]   cmd;
  logic [okvt_pkg::KEY_W-1:0]   key;
  logic [okvt_pkg::VALUE_W-1:0] value;
  logic                        may_insert;
  logic                        may_update;
  logic [okvt_pkg::POS_W-1:0]   position;

  modport source (
    output valid, cmd, key, value, may_insert, may_update, position,
    input  ready
  );
  modport sink (
    input  valid, cmd, key, value, may_insert, may_update, position,
    output ready
  );
endinterface

interface okvt_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [okvt_pkg::KEY_W-1:0]   key_out;
  logic [okvt_pkg::VALUE_W-1:0] value_out;
  logic                        full_flag;
  logic [okvt_pkg::COUNT_W-1:0] entry_count;

  modport source (
    output valid, ok, key_out, value_out, full_flag, entry_count,
    input  ready
  );
  modport sink (
    input  valid, ok, key_out, value_out, full_flag, entry_count,
    output ready
  );
endinterface

>>> hdl/ordered_key_value_table.sv
// ----------------------------------------------------------------------------
// ordered_key_value_table
// Key-value table kept in insertion order, searched one entry per cycle.
// ----------------------------------------------------------------------------
//   channel  direction  fields
//   req_i    in         cmd, key, value, may_insert, may_update, position
//   rsp_o    out        ok, key_out, value_out, full_flag, entry_count
//
// A search reads one stored entry per cycle through the single read port of
// the entry memory and stops at the matching entry. A miss reads every
// stored entry, and so does an erase, which goes on past the match to move
// each later entry down one place; hits of put and get by key end sooner.
// Get by index reads the entry at the given position directly. req_i.ready
// is high only while idle. Reset empties the table at once; no memory pass
// follows. A result waits in the output register while rsp_o.ready is low.
// ----------------------------------------------------------------------------
module ordered_key_value_table #(
  parameter int unsigned DEPTH      = okvt_pkg::DEPTH_DEF,
  parameter int unsigned KEY_BITS   = okvt_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = okvt_pkg::VALUE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  okvt_req_if.sink   req_i,
  okvt_rsp_if.source rsp_o
);

  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned EntW  = KEY_BITS + VALUE_BITS;
  localparam int unsigned CmpW  = CntW + okvt_pkg::POS_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_READ  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Control registers.
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] addr_q, addr_d;
  logic [CntW-1:0] rd_idx_q, rd_idx_d;
  logic            rd_vld_q, rd_vld_d;
  logic            rsp_vld_q, rsp_vld_d;

  // Latched command and result.
  okvt_pkg::cmd_e             cmd_q, cmd_d;
  logic [KEY_BITS-1:0]        key_q, key_d;
  logic [VALUE_BITS-1:0]      value_q, value_d;
  logic                       ins_q, ins_d;
  logic                       upd_q, upd_d;
  logic [okvt_pkg::POS_W-1:0] pos_q, pos_d;
  logic                       ok_q, ok_d;
  logic [okvt_pkg::KEY_W-1:0]   kout_q, kout_d;
  logic [okvt_pkg::VALUE_W-1:0] vout_q, vout_d;
  logic                       full_q, full_d;

  // Output register.
  logic                         o_ok_q, o_ok_d;
  logic [okvt_pkg::KEY_W-1:0]   o_key_q, o_key_d;
  logic [okvt_pkg::VALUE_W-1:0] o_val_q, o_val_d;
  logic                         o_full_q, o_full_d;
  logic [okvt_pkg::COUNT_W-1:0] o_cnt_q, o_cnt_d;

  okvt_pkg::mem_ctl_t mem_ctl;
  logic [AddrW-1:0]   waddr;
  logic [EntW-1:0]    wdata;
  logic [AddrW-1:0]   raddr;
  logic [EntW-1:0]    rdata;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  logic accept;
  logic hit;
  logic scan_end;
  logic pos_ok;

  okvt_store #(
    .DEPTH (DEPTH),
    .WIDTH (EntW)
  ) u_store (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_key   = rdata[EntW-1:VALUE_BITS];
  assign rd_val   = rdata[VALUE_BITS-1:0];
  assign accept   = req_i.valid && req_i.ready;
  assign hit      = rd_vld_q && (rd_key == key_q);
  // Every valid entry has been compared and none matched.
  assign scan_end = !rd_vld_q && (addr_q >= count_q);
  assign pos_ok   = CmpW'(pos_q) < CmpW'(count_q);

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = rsp_vld_q;
  assign rsp_o.ok          = o_ok_q;
  assign rsp_o.key_out     = o_key_q;
  assign rsp_o.value_out   = o_val_q;
  assign rsp_o.full_flag   = o_full_q;
  assign rsp_o.entry_count = o_cnt_q;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    addr_d    = addr_q;
    rd_idx_d  = rd_idx_q;
    rd_vld_d  = rd_vld_q;
    rsp_vld_d = rsp_vld_q && !rsp_o.ready;
    cmd_d     = cmd_q;
    key_d     = key_q;
    value_d   = value_q;
    ins_d     = ins_q;
    upd_d     = upd_q;
    pos_d     = pos_q;
    ok_d      = ok_q;
    kout_d    = kout_q;
    vout_d    = vout_q;
    full_d    = full_q;
    o_ok_d    = o_ok_q;
    o_key_d   = o_key_q;
    o_val_d   = o_val_q;
    o_full_d  = o_full_q;
    o_cnt_d   = o_cnt_q;
    mem_ctl   = '0;
    waddr     = '0;
    wdata     = '0;
    raddr     = addr_q[AddrW-1:0];

    // The read pipeline walks the entries in order while scanning or
    // compacting; rd_idx_q names the entry now on the read data.
    if (state_q == S_SCAN || state_q == S_SHIFT) begin
      mem_ctl.rd_en = 1'b1;
      rd_vld_d      = addr_q < count_q;
      rd_idx_d      = addr_q;
      if (addr_q < count_q) begin
        addr_d = addr_q + 1'b1;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d    = okvt_pkg::cmd_e'(req_i.cmd);
          key_d    = KEY_BITS'(req_i.key);
          value_d  = VALUE_BITS'(req_i.value);
          ins_d    = req_i.may_insert;
          upd_d    = req_i.may_update;
          pos_d    = req_i.position;
          ok_d     = 1'b0;
          kout_d   = '0;
          vout_d   = '0;
          full_d   = 1'b0;
          addr_d   = '0;
          rd_vld_d = 1'b0;
          if (okvt_pkg::cmd_e'(req_i.cmd) == okvt_pkg::CMD_GET_POS) begin
            mem_ctl.rd_en = 1'b1;
            raddr         = AddrW'(req_i.position);
            state_d       = S_READ;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          unique case (cmd_q)
            okvt_pkg::CMD_PUT: begin
              if (upd_q) begin
                mem_ctl.wr_en = 1'b1;
                waddr         = rd_idx_q[AddrW-1:0];
                wdata         = {key_q, value_q};
                ok_d          = 1'b1;
              end
              state_d = S_DONE;
            end
            okvt_pkg::CMD_ERASE: begin
              state_d = S_SHIFT;
            end
            okvt_pkg::CMD_GET_KEY: begin
              vout_d  = okvt_pkg::VALUE_W'(rd_val);
              ok_d    = 1'b1;
              state_d = S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end else if (scan_end) begin
          if (cmd_q == okvt_pkg::CMD_PUT && ins_q) begin
            if (count_q == CntW'(DEPTH)) begin
              full_d = 1'b1;
            end else begin
              mem_ctl.wr_en = 1'b1;
              waddr         = count_q[AddrW-1:0];
              wdata         = {key_q, value_q};
              count_d       = count_q + 1'b1;
              ok_d          = 1'b1;
            end
          end
          state_d = S_DONE;
        end
      end
      S_SHIFT: begin
        if (rd_vld_q) begin
          mem_ctl.wr_en = 1'b1;
          waddr         = AddrW'(rd_idx_q - 1'b1);
          wdata         = rdata;
        end else begin
          count_d = count_q - 1'b1;
          ok_d    = 1'b1;
          state_d = S_DONE;
        end
      end
      S_READ: begin
        if (pos_ok) begin
          ok_d   = 1'b1;
          kout_d = okvt_pkg::KEY_W'(rd_key);
          vout_d = okvt_pkg::VALUE_W'(rd_val);
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!rsp_vld_q || rsp_o.ready) begin
          o_ok_d    = ok_q;
          o_key_d   = kout_q;
          o_val_d   = vout_q;
          o_full_d  = full_q;
          o_cnt_d   = okvt_pkg::COUNT_W'(count_q);
          rsp_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      addr_q    <= '0;
      rd_idx_q  <= '0;
      rd_vld_q  <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      addr_q    <= addr_d;
      rd_idx_q  <= rd_idx_d;
      rd_vld_q  <= rd_vld_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    key_q    <= key_d;
    value_q  <= value_d;
    ins_q    <= ins_d;
    upd_q    <= upd_d;
    pos_q    <= pos_d;
    ok_q     <= ok_d;
    kout_q   <= kout_d;
    vout_q   <= vout_d;
    full_q   <= full_d;
    o_ok_q   <= o_ok_d;
    o_key_q  <= o_key_d;
    o_val_q  <= o_val_d;
    o_full_q <= o_full_d;
    o_cnt_q  <= o_cnt_d;
  end

`ifndef NO_ASSERTIONS
  a_count_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count exceeds table depth");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != count_d |-> (state_q == S_SCAN || state_q == S_SHIFT))
    else $error("entry count changed outside a search or erase");

  a_write_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctl.wr_en |-> (state_q == S_SCAN || state_q == S_SHIFT))
    else $error("memory written outside a search or erase");

  a_one_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !req_i.ready)
    else $error("second item accepted while one is in work");

  a_full_not_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_vld_q |-> !(o_ok_q && o_full_q))
    else $error("result reports success and a full table together");
`endif

endmodule

>>> hdl/okvt_store.sv
// ----------------------------------------------------------------------------
// okvt_store
// Entry memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module okvt_store #(
  parameter int unsigned DEPTH = okvt_pkg::DEPTH_DEF,
  parameter int unsigned WIDTH = okvt_pkg::KEY_BITS_DEF + okvt_pkg::VALUE_BITS_DEF
) (
  input  logic                     clk_i,
  input  okvt_pkg::mem_ctl_t       ctl_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> dv/okvt_table_checker.sv
// ----------------------------------------------------------------------------
// okvt_table_checker
// Watches both channels of the ordered key-value table. Keeps its own copy
// of the table to predict one result per accepted command, and compares
// every accepted result with the oldest prediction still pending.
// ----------------------------------------------------------------------------
module okvt_table_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  okvt_req_if         req_mon,
  okvt_rsp_if         rsp_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import okvt_pkg::*;

  localparam int unsigned TABLE_DEPTH = DEPTH_DEF;
  localparam int unsigned REPORT_MAX  = 10;

  typedef struct packed {
    logic               ok;
    logic [KEY_W-1:0]   key_out;
    logic [VALUE_W-1:0] value_out;
    logic               full_flag;
    logic [COUNT_W-1:0] entry_count;
  } table_result_t;

  logic [KEY_W-1:0]   shadow_keys   [TABLE_DEPTH];
  logic [VALUE_W-1:0] shadow_values [TABLE_DEPTH];
  int unsigned        shadow_count;
  table_result_t      expected_results_q [$];
  int unsigned        fail_total;

  // Runs one command on the shadow table and returns the result it yields.
  function automatic table_result_t run_table_command(
    cmd_e               cmd,
    logic [KEY_W-1:0]   key,
    logic [VALUE_W-1:0] value,
    logic               may_insert,
    logic               may_update,
    logic [POS_W-1:0]   position
  );
    table_result_t res;
    int unsigned   hit;
    res = '0;
    hit = shadow_count;
    for (int unsigned p = 0; p < shadow_count; p++) begin
      if (shadow_keys[p] == key) begin
        hit = p;
        break;
      end
    end
    case (cmd)
      CMD_PUT: begin
        if (hit < shadow_count) begin
          if (may_update) begin
            shadow_values[hit] = value;
            res.ok = 1'b1;
          end
        end else if (may_insert) begin
          if (shadow_count >= TABLE_DEPTH) begin
            res.full_flag = 1'b1;
          end else begin
            shadow_keys[shadow_count]   = key;
            shadow_values[shadow_count] = value;
            shadow_count++;
            res.ok = 1'b1;
          end
        end
      end
      CMD_ERASE: begin
        if (hit < shadow_count) begin
          // Later entries move down one place so the order is kept.
          for (int unsigned p = hit; p + 1 < shadow_count; p++) begin
            shadow_keys[p]   = shadow_keys[p + 1];
            shadow_values[p] = shadow_values[p + 1];
          end
          shadow_count--;
          res.ok = 1'b1;
        end
      end
      CMD_GET_KEY: begin
        if (hit < shadow_count) begin
          res.value_out = shadow_values[hit];
          res.ok        = 1'b1;
        end
      end
      default: begin
        if (position < shadow_count) begin
          res.key_out   = shadow_keys[position];
          res.value_out = shadow_values[position];
          res.ok        = 1'b1;
        end
      end
    endcase
    res.entry_count = shadow_count[COUNT_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    table_result_t got;
    table_result_t want;
    if (!rst_ni) begin
      shadow_count = 0;
      fail_total   = 0;
      expected_results_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.ok          = rsp_mon.ok;
        got.key_out     = rsp_mon.key_out;
        got.value_out   = rsp_mon.value_out;
        got.full_flag   = rsp_mon.full_flag;
        got.entry_count = rsp_mon.entry_count;
        if (expected_results_q.size() == 0) begin
          fail_total++;
          if (fail_total <= REPORT_MAX) begin
            $display("%0t: result with no command pending:", $realtime);
            $display("  actual   ok=%0b key=%h value=%h full=%0b count=%0d",
                     got.ok, got.key_out, got.value_out, got.full_flag,
                     got.entry_count);
          end
        end else begin
          want = expected_results_q.pop_front();
          if (got.ok !== want.ok || got.key_out !== want.key_out ||
              got.value_out !== want.value_out || got.full_flag !== want.full_flag ||
              got.entry_count !== want.entry_count) begin
            fail_total++;
            if (fail_total <= REPORT_MAX) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected ok=%0b key=%h value=%h full=%0b count=%0d",
                       want.ok, want.key_out, want.value_out, want.full_flag,
                       want.entry_count);
              $display("  actual   ok=%0b key=%h value=%h full=%0b count=%0d",
                       got.ok, got.key_out, got.value_out, got.full_flag,
                       got.entry_count);
            end
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        expected_results_q.push_back(run_table_command(cmd_e'(req_mon.cmd), req_mon.key,
                                                       req_mon.value, req_mon.may_insert,
                                                       req_mon.may_update,
                                                       req_mon.position));
      end
      fail_count_o <= fail_total;
      pending_o    <= expected_results_q.size();
    end
  end

endmodule

>>> dv/tb_ordered_key_value_table.sv
// ----------------------------------------------------------------------------
// tb_ordered_key_value_table
// Drives commands into the ordered key-value table: a directed opening for
// the edge cases, then random phases that fill, drain and mix the table,
// with random gaps on both channels. The checker judges every result.
// ----------------------------------------------------------------------------
module tb_ordered_key_value_table;
  timeunit 1ns;
  timeprecision 1ps;

  import okvt_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1030;
  localparam int unsigned POOL_SIZE    = 80;
  localparam int unsigned PHASE_LEN    = 150;
  localparam int unsigned SETTLE_CYCLES = 200;

  logic clk_i;
  logic rst_ni;

  okvt_req_if req_ch ();
  okvt_rsp_if rsp_ch ();

  int unsigned fail_count;
  int unsigned pending;
  bit          sender_calm;
  bit          receiver_calm;
  int unsigned pool_cursor;

  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  ordered_key_value_table uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  okvt_table_checker table_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_ch),
    .rsp_mon      (rsp_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  initial begin
    #16_000_000;
    $display("** ordered_key_value_table: FAILED **");
    $finish;
  end

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_ch.ready <= receiver_calm || ($urandom_range(99) >= 10);
    end
  end

  task automatic send_command(
    cmd_e               cmd,
    logic [KEY_W-1:0]   key,
    logic [VALUE_W-1:0] value,
    logic               may_insert,
    logic               may_update,
    logic [POS_W-1:0]   position
  );
    while (!sender_calm && $urandom_range(99) < 10) begin
      @(negedge clk_i);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    req_ch.valid      <= 1'b1;
    req_ch.cmd        <= cmd;
    req_ch.key        <= key;
    req_ch.value      <= value;
    req_ch.may_insert <= may_insert;
    req_ch.may_update <= may_update;
    req_ch.position   <= position;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // Stops sending and waits until every pending result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Fill phases walk the key pool in order so the table reaches full,
  // drain phases mostly erase, and mixed phases do a bit of everything.
  task automatic send_random_command(int unsigned index);
    int unsigned      mode;
    int unsigned      roll;
    cmd_e             cmd;
    logic [KEY_W-1:0] key;
    mode = (index / PHASE_LEN) % 3;
    roll = $urandom_range(99);
    case (mode)
      0:       cmd = roll < 75 ? CMD_PUT : roll < 80 ? CMD_ERASE :
                     roll < 90 ? CMD_GET_KEY : CMD_GET_POS;
      1:       cmd = roll < 15 ? CMD_PUT : roll < 70 ? CMD_ERASE :
                     roll < 85 ? CMD_GET_KEY : CMD_GET_POS;
      default: cmd = roll < 35 ? CMD_PUT : roll < 60 ? CMD_ERASE :
                     roll < 80 ? CMD_GET_KEY : CMD_GET_POS;
    endcase
    if ($urandom_range(99) < 10) begin
      key = $urandom;
    end else if (mode == 0 && cmd == CMD_PUT && $urandom_range(99) < 80) begin
      key = key_pool[pool_cursor];
      pool_cursor = (pool_cursor + 1) % POOL_SIZE;
    end else begin
      key = key_pool[$urandom_range(POOL_SIZE - 1)];
    end
    send_command(cmd, key, $urandom, $urandom_range(99) < 85, $urandom_range(99) < 85,
                 POS_W'($urandom_range(63)));
  endtask

  initial begin
    rst_ni            = 1'b0;
    sender_calm       = 1'b0;
    receiver_calm     = 1'b0;
    pool_cursor       = 0;
    req_ch.valid      = 1'b0;
    req_ch.cmd        = CMD_PUT;
    req_ch.key        = '0;
    req_ch.value      = '0;
    req_ch.may_insert = 1'b0;
    req_ch.may_update = 1'b0;
    req_ch.position   = '0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int unsigned p = 2; p < POOL_SIZE; p++) key_pool[p] = $urandom;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reads and erases on an empty table, refused and accepted inserts,
    // refused and accepted updates, reads at and past the end, an erase
    // from the front that shifts the rest down.
    send_command(CMD_GET_POS, '0, '0, 1'b0, 1'b0, 6'd0);
    send_command(CMD_GET_KEY, '0, '0, 1'b0, 1'b0, 6'd0);
    send_command(CMD_ERASE, '1, '1, 1'b1, 1'b1, 6'd63);
    send_command(CMD_PUT, 32'd5, 32'd7, 1'b0, 1'b1, 6'd0);
    send_command(CMD_PUT, '0, '1, 1'b1, 1'b0, 6'd0);
    send_command(CMD_PUT, '1, '0, 1'b1, 1'b1, 6'd0);
    send_command(CMD_PUT, 32'h8000_0001, 32'h1234_5678, 1'b1, 1'b0, 6'd0);
    send_command(CMD_PUT, '0, 32'hA5A5_A5A5, 1'b1, 1'b0, 6'd0);
    send_command(CMD_PUT, '0, 32'h5A5A_5A5A, 1'b0, 1'b1, 6'd0);
    send_command(CMD_GET_KEY, '0, '0, 1'b0, 1'b0, 6'd0);
    send_command(CMD_GET_KEY, '1, '0, 1'b0, 1'b0, 6'd0);
    send_command(CMD_GET_KEY, 32'h0001_2345, '0, 1'b0, 1'b0, 6'd0);
    send_command(CMD_GET_POS, '0, '0, 1'b0, 1'b0, 6'd1);
    send_command(CMD_GET_POS, '0, '0, 1'b0, 1'b0, 6'd2);
    send_command(CMD_GET_POS, '0, '0, 1'b0, 1'b0, 6'd3);
    send_command(CMD_GET_POS, '0, '0, 1'b0, 1'b0, 6'd63);
    send_command(CMD_ERASE, '0, '0, 1'b0, 1'b0, 6'd0);
    send_command(CMD_GET_POS, '0, '0, 1'b0, 1'b0, 6'd0);
    send_command(CMD_GET_POS, '0, '0, 1'b0, 1'b0, 6'd1);
    send_command(CMD_ERASE, '0, '0, 1'b1, 1'b1, 6'd0);
    send_command(CMD_PUT, '0, '1, 1'b0, 1'b0, 6'd0);

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 300) drain_results();
      sender_calm   = (i >= 500 && i < 700);
      receiver_calm = sender_calm;
      send_random_command(i);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("** ordered_key_value_table: PASSED **");
    end else begin
      $display("** ordered_key_value_table: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/okvt_pkg.sv
hdl/okvt_if.sv
hdl/okvt_store.sv
hdl/ordered_key_value_table.sv
dv/okvt_table_checker.sv
dv/tb_ordered_key_value_table.sv
